>>> design/uts_pkg.sv
// Shared constants, types and helper functions for the UTF-16 text sanitizer.
// No dependencies; used by every other file of the block.
package uts_pkg;

  // width of the UTF-8 byte counter
  localparam int BUDGET_BITS = 16;
  localparam int UNIT_W      = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int CMP_W       = 33;

  // largest budget the counter can represent
  localparam logic [CMP_W-1:0] BudgetCap = (CMP_W'(1) << BUDGET_BITS) - CMP_W'(1);

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_BYTES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEEP_WS   = 2'd1;

  localparam logic [CFG_DATA_W-1:0] MAX_BYTES_RESET = 16'd4096;

  // code points with special handling
  localparam logic [UNIT_W-1:0] CP_REPL     = 16'hFFFD;
  localparam logic [UNIT_W-1:0] CP_TAB      = 16'h0009;
  localparam logic [UNIT_W-1:0] CP_LF       = 16'h000A;
  localparam logic [UNIT_W-1:0] CP_CR       = 16'h000D;
  localparam logic [UNIT_W-1:0] CP_C0_LAST  = 16'h001F;
  localparam logic [UNIT_W-1:0] CP_DEL      = 16'h007F;
  localparam logic [UNIT_W-1:0] CP_C1_LAST  = 16'h009F;
  localparam logic [UNIT_W-1:0] CP_ASCII_LAST = 16'h007F;
  localparam logic [UNIT_W-1:0] CP_TWO_LAST = 16'h07FF;
  localparam logic [5:0]        HIGH_TAG    = 6'b110110;

  // UTF-8 lengths
  localparam logic [2:0] LEN_BMP3 = 3'd3;
  localparam logic [2:0] LEN_PAIR = 3'd4;

  // one result item
  typedef struct packed {
    logic [UNIT_W-1:0] out_unit;
    logic              unit_valid;
    logic              run_last;
    logic              text_end;
  } res_t;

  // results caused by one input item
  typedef res_t [2:0] res_arr_t;

  // status of the result buffer
  typedef struct packed {
    logic       can_load;
    logic [1:0] level;
  } buf_stat_t;

  // status of the text state
  typedef struct packed {
    logic held_valid;
    logic budget_hit;
    logic bytes_zero;
  } step_stat_t;

  function automatic logic is_high(input logic [UNIT_W-1:0] u);
    return u[15:10] == 6'b110110;
  endfunction

  function automatic logic is_low(input logic [UNIT_W-1:0] u);
    return u[15:10] == 6'b110111;
  endfunction

  function automatic logic is_surrogate(input logic [UNIT_W-1:0] u);
    return u[15:11] == 5'b11011;
  endfunction

  function automatic logic is_control(input logic [UNIT_W-1:0] cp);
    return (cp <= CP_C0_LAST) || ((cp >= CP_DEL) && (cp <= CP_C1_LAST));
  endfunction

  function automatic logic [2:0] utf8_len(input logic [UNIT_W-1:0] cp);
    logic [2:0] len;
    if (cp <= CP_ASCII_LAST) begin
      len = 3'd1;
    end else if (cp <= CP_TWO_LAST) begin
      len = 3'd2;
    end else begin
      len = LEN_BMP3;
    end
    return len;
  endfunction

  // true when len more bytes stay within the limit
  function automatic logic fits(input logic [BUDGET_BITS-1:0] used,
                                input logic [2:0] len,
                                input logic [CMP_W-1:0] lim);
    return (CMP_W'(used) + CMP_W'(len)) <= lim;
  endfunction

endpackage

>>> design/uts_if.sv
// Channel interfaces of the UTF-16 text sanitizer: input units, results, configuration.
// Depends on uts_pkg for field widths.
interface uts_unit_if;
  logic                       valid;
  logic                       ready;
  logic [uts_pkg::UNIT_W-1:0] code_unit;
  logic                       text_last;
  modport source (output valid, code_unit, text_last, input ready);
  modport sink (input valid, code_unit, text_last, output ready);
endinterface

interface uts_result_if;
  logic                       valid;
  logic                       ready;
  logic [uts_pkg::UNIT_W-1:0] out_unit;
  logic                       unit_valid;
  logic                       run_last;
  logic                       text_end;
  modport source (output valid, out_unit, unit_valid, run_last, text_end, input ready);
  modport sink (input valid, out_unit, unit_valid, run_last, text_end, output ready);
endinterface

interface uts_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [uts_pkg::CFG_IDX_W-1:0]  index;
  logic [uts_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> design/uts_step.sv
// Per-unit sanitizing step: text state registers and the logic that turns one
// code unit into up to three results. Depends on uts_pkg.
module uts_step (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  logic [uts_pkg::UNIT_W-1:0]      unit,
  input  logic                            text_last,
  input  logic [uts_pkg::CFG_DATA_W-1:0]  max_bytes,
  input  logic                            keep_ws,
  output uts_pkg::res_arr_t               res,
  output logic [1:0]                      res_count,
  output uts_pkg::step_stat_t             stat
);

  logic [9:0]                       held_high_bits;
  logic                             held_valid;
  logic                             skip_next_lf;
  logic [uts_pkg::BUDGET_BITS-1:0]  bytes_used;
  logic                             budget_hit;

  logic [9:0]                       held_high_bits_next;
  logic                             held_valid_next;
  logic                             skip_next_lf_next;
  logic [uts_pkg::BUDGET_BITS-1:0]  bytes_used_next;
  logic                             budget_hit_next;

  logic [uts_pkg::CMP_W-1:0]        lim;

  // budget saturated to what the counter can hold
  assign lim = (uts_pkg::CMP_W'(max_bytes) > uts_pkg::BudgetCap) ?
               uts_pkg::BudgetCap : uts_pkg::CMP_W'(max_bytes);

  // decode one unit against the held state
  always_comb begin
    logic                  go_fresh;
    logic                  was_cr;
    logic [uts_pkg::UNIT_W-1:0] cp;
    logic [2:0]            len;
    logic [1:0]            n;

    held_high_bits_next = held_high_bits;
    held_valid_next     = held_valid;
    skip_next_lf_next   = skip_next_lf;
    bytes_used_next     = bytes_used;
    budget_hit_next     = budget_hit;
    res                 = '0;
    n                   = 2'd0;
    go_fresh            = 1'b0;
    was_cr              = 1'b0;
    cp                  = '0;
    len                 = '0;

    if (!budget_hit) begin
      skip_next_lf_next = 1'b0;
      if (skip_next_lf && (unit == uts_pkg::CP_LF)) begin
        // lf right after a cr is dropped
        go_fresh = 1'b0;
      end else if (held_valid) begin
        held_valid_next     = 1'b0;
        held_high_bits_next = '0;
        if (uts_pkg::is_low(unit)) begin
          // complete pair, costs four bytes
          if (uts_pkg::fits(bytes_used_next, uts_pkg::LEN_PAIR, lim)) begin
            res[0].out_unit   = {uts_pkg::HIGH_TAG, held_high_bits};
            res[0].unit_valid = 1'b1;
            res[1].out_unit   = unit;
            res[1].unit_valid = 1'b1;
            n                 = 2'd2;
            bytes_used_next   = bytes_used_next +
                                uts_pkg::BUDGET_BITS'(uts_pkg::LEN_PAIR);
          end else begin
            budget_hit_next = 1'b1;
          end
        end else begin
          // orphan high surrogate gets a replacement first
          if (uts_pkg::fits(bytes_used_next, uts_pkg::LEN_BMP3, lim)) begin
            res[0].out_unit   = uts_pkg::CP_REPL;
            res[0].unit_valid = 1'b1;
            n                 = 2'd1;
            bytes_used_next   = bytes_used_next +
                                uts_pkg::BUDGET_BITS'(uts_pkg::LEN_BMP3);
            go_fresh          = 1'b1;
          end else begin
            budget_hit_next = 1'b1;
          end
        end
      end else begin
        go_fresh = 1'b1;
      end

      // unit with nothing pending
      if (go_fresh) begin
        if (uts_pkg::is_high(unit) && !text_last) begin
          held_valid_next     = 1'b1;
          held_high_bits_next = unit[9:0];
        end else begin
          cp = uts_pkg::is_surrogate(unit) ? uts_pkg::CP_REPL : unit;
          if (cp == uts_pkg::CP_CR) begin
            cp     = uts_pkg::CP_LF;
            was_cr = 1'b1;
          end else if (uts_pkg::is_control(cp) &&
                       !(keep_ws && ((cp == uts_pkg::CP_TAB) || (cp == uts_pkg::CP_LF)))) begin
            cp = uts_pkg::CP_REPL;
          end
          len = uts_pkg::utf8_len(cp);
          if (uts_pkg::fits(bytes_used_next, len, lim)) begin
            res[n].out_unit   = cp;
            res[n].unit_valid = 1'b1;
            n                 = n + 2'd1;
            bytes_used_next   = bytes_used_next + uts_pkg::BUDGET_BITS'(len);
            skip_next_lf_next = was_cr;
          end else begin
            budget_hit_next     = 1'b1;
            held_valid_next     = 1'b0;
            held_high_bits_next = '0;
            skip_next_lf_next   = 1'b0;
          end
        end
      end
    end

    // end marker closes the text and clears the state (n is at most two here)
    if (text_last) begin
      res[n].text_end     = 1'b1;
      n                   = n + 2'd1;
      held_high_bits_next = '0;
      held_valid_next     = 1'b0;
      skip_next_lf_next   = 1'b0;
      bytes_used_next     = '0;
      budget_hit_next     = 1'b0;
    end

    if (n != 2'd0) begin
      res[n - 2'd1].run_last = 1'b1;
    end
    res_count = n;
  end

  // text state
  always_ff @(posedge clk) begin
    if (rst) begin
      held_high_bits <= '0;
      held_valid     <= 1'b0;
      skip_next_lf   <= 1'b0;
      bytes_used     <= '0;
      budget_hit     <= 1'b0;
    end else if (en) begin
      held_high_bits <= held_high_bits_next;
      held_valid     <= held_valid_next;
      skip_next_lf   <= skip_next_lf_next;
      bytes_used     <= bytes_used_next;
      budget_hit     <= budget_hit_next;
    end
  end

  assign stat.held_valid = held_valid;
  assign stat.budget_hit = budget_hit;
  assign stat.bytes_zero = (bytes_used == '0);

endmodule

>>> design/uts_out_buf.sv
// Result buffer: holds the up to three results of one unit and hands them out
// one per cycle while result_out.ready is high. Depends on uts_pkg and uts_if.
module uts_out_buf (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  uts_pkg::res_arr_t     res,
  input  logic [1:0]            res_count,
  output uts_pkg::buf_stat_t    stat,
  uts_result_if.source          res_out
);

  uts_pkg::res_arr_t ent;
  logic [1:0]        level;
  logic [1:0]        ptr;
  logic              take;

  assign res_out.valid      = (level != 2'd0);
  assign res_out.out_unit   = ent[ptr].out_unit;
  assign res_out.unit_valid = ent[ptr].unit_valid;
  assign res_out.run_last   = ent[ptr].run_last;
  assign res_out.text_end   = ent[ptr].text_end;
  assign take               = res_out.valid && res_out.ready;

  // new results may come in once the last held one leaves
  assign stat.can_load = (level == 2'd0) || ((level == 2'd1) && take);
  assign stat.level    = level;

  // fill level and read pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      level <= 2'd0;
      ptr   <= 2'd0;
    end else if (load) begin
      level <= res_count;
      ptr   <= 2'd0;
    end else if (take) begin
      level <= level - 2'd1;
      ptr   <= ptr + 2'd1;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (load) begin
      ent <= res;
    end
  end

endmodule

>>> design/utf16_text_sanitizer.sv
// Top level of the UTF-16 text sanitizer with a UTF-8 byte budget.
// Depends on uts_pkg, uts_if, uts_step and uts_out_buf.
//
//   channel     dir  handshake     payload
//   text_in     in   valid/ready   code_unit[15:0], text_last
//   result_out  out  valid/ready   out_unit[15:0], unit_valid, run_last, text_end
//   cfg         in   valid/ready   index[1:0], data[15:0] (ready always high)
//
// A request lands in an input register, and once the result buffer can load, its zero to three
// results are loaded into the result buffer.
// The buffer sends one result per cycle while result_out.ready is high. Results per unit:
// one for plain units, two for pairs or a unit with a replacement, up to three at text end.
// A new request is taken while the last buffered result is being sent.
// rst clears all control and text state; max_utf8_bytes resets to 4096 and keep_whitespace to 0.
module utf16_text_sanitizer (
  input  logic        clk,
  input  logic        rst,
  uts_unit_if.sink    text_in,
  uts_result_if.source result_out,
  uts_cfg_if.sink     cfg
);

  logic [uts_pkg::CFG_DATA_W-1:0] max_bytes;
  logic                           keep_ws;

  logic                           ir_valid;
  logic [uts_pkg::UNIT_W-1:0]     ir_unit;
  logic                           ir_last;
  logic                           consume;

  uts_pkg::res_arr_t              res;
  logic [1:0]                     res_count;
  uts_pkg::buf_stat_t             bstat;
  uts_pkg::step_stat_t            sstat;

  // configuration registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_bytes <= uts_pkg::MAX_BYTES_RESET;
      keep_ws   <= 1'b0;
    end else if (cfg.valid) begin
      case (cfg.index)
        uts_pkg::CFG_MAX_BYTES: max_bytes <= cfg.data;
        uts_pkg::CFG_KEEP_WS:   keep_ws   <= cfg.data[0];
        default: ;
      endcase
    end
  end

  // input register
  assign consume       = ir_valid && bstat.can_load;
  assign text_in.ready = !ir_valid || consume;

  always_ff @(posedge clk) begin
    if (rst) begin
      ir_valid <= 1'b0;
    end else if (text_in.ready) begin
      ir_valid <= text_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (text_in.valid && text_in.ready) begin
      ir_unit <= text_in.code_unit;
      ir_last <= text_in.text_last;
    end
  end

  // sanitizing step
  uts_step u_step (
    .clk       (clk),
    .rst       (rst),
    .en        (consume),
    .unit      (ir_unit),
    .text_last (ir_last),
    .max_bytes (max_bytes),
    .keep_ws   (keep_ws),
    .res       (res),
    .res_count (res_count),
    .stat      (sstat)
  );

  // result buffer
  uts_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .load      (consume),
    .res       (res),
    .res_count (res_count),
    .stat      (bstat),
    .res_out   (result_out)
  );

  // results are loaded only into a buffer that is empty or draining its last entry
  a_load_room: assert property (@(posedge clk) disable iff (rst)
    consume |-> (bstat.level == 2'd0) ||
                ((bstat.level == 2'd1) && result_out.valid && result_out.ready))
    else $error("result buffer overwritten");

  // the end of a text leaves the state cleared
  a_text_reset: assert property (@(posedge clk) disable iff (rst)
    (consume && ir_last) |=> (sstat.bytes_zero && !sstat.held_valid && !sstat.budget_hit))
    else $error("state not cleared at text end");

  // the end marker carries no unit and closes its request
  a_marker: assert property (@(posedge clk) disable iff (rst)
    (result_out.valid && result_out.text_end) |-> (result_out.run_last && !result_out.unit_valid))
    else $error("malformed end marker");

  // a held request is not dropped while the buffer is busy
  a_hold_input: assert property (@(posedge clk) disable iff (rst)
    (ir_valid && !consume) |=> (ir_valid && $stable(ir_unit) && $stable(ir_last)))
    else $error("input register lost a request");

endmodule
